>>> hdl/tdaq_pkg.sv
// tdaq_pkg.sv: shared types, thresholds and level mapping for the quantizer
`default_nettype none

package tdaq_pkg;

    localparam int unsigned SampleWidth    = 16;
    localparam int unsigned LevelWidth     = 4;
    localparam int unsigned ThresholdCount = 16;
    localparam int unsigned CountWidth     = $clog2(ThresholdCount + 1);

    localparam logic signed [SampleWidth-1:0] THRESHOLDS [ThresholdCount] = '{
        -16'sd30721, -16'sd27701, -16'sd24681, -16'sd21661,
        -16'sd18641, -16'sd15621, -16'sd12601, -16'sd9581,
        16'sd9580,   16'sd12600,  16'sd15620,  16'sd18640,
        16'sd21660,  16'sd24680,  16'sd27700,  16'sd30720
    };

    // code value that would mean -8, never produced
    localparam logic signed [LevelWidth-1:0] LEVEL_NEG_FULL = 4'sb1000;

    typedef struct packed {
        logic signed [SampleWidth-1:0] x_value;
        logic signed [SampleWidth-1:0] y_value;
    } in_t;

    typedef struct packed {
        logic signed [LevelWidth-1:0] x_level;
        logic signed [LevelWidth-1:0] y_level;
    } out_t;

    // rising: thresholds at or below the sample; falling: strictly below.
    // both paths reduce to clamping the count to 1..15 and removing the offset of 8
    function automatic logic signed [LevelWidth-1:0] quantize(
        input logic signed [SampleWidth-1:0] sample,
        input logic signed [SampleWidth-1:0] previous
    );
        logic                  rising;
        logic [CountWidth-1:0] cnt;
        logic [LevelWidth-1:0] code;
        rising = (sample >= previous);
        cnt = '0;
        for (int i = 0; i < ThresholdCount; i++) begin
            if (rising ? (THRESHOLDS[i] <= sample) : (THRESHOLDS[i] < sample)) begin
                cnt = cnt + CountWidth'(1);
            end
        end
        if (cnt == '0) begin
            code = LevelWidth'(1);
        end else if (cnt > CountWidth'(ThresholdCount - 1)) begin
            code = LevelWidth'(ThresholdCount - 1);
        end else begin
            code = cnt[LevelWidth-1:0];
        end
        return signed'(code ^ LEVEL_NEG_FULL);
    endfunction

endpackage

`default_nettype wire

>>> hdl/two_axis_direction_aware_quantizer_core.sv
// Two-axis direction-aware quantizer: one X/Y sample pair in, one pair of
// levels (-7..+7) out per transfer. Each axis is compared against 16 fixed
// thresholds; a sample at or above the previous one on its axis counts the
// thresholds at or below it, a falling sample counts those strictly below it,
// which puts one level of hysteresis at each threshold. The previous samples
// reset to zero. Throughput is one transfer per cycle while m_ready does not
// stall the output; an input transfer is held in the input register, then
// passes the comparator bank into the result register. A waiting result does
// not block the next input transfer while the input register is free.
`default_nettype none

module two_axis_direction_aware_quantizer_core (
    input  wire           aclk,
    input  wire           aresetn,
    input  wire           s_valid,
    output logic          s_ready,
    input  tdaq_pkg::in_t s_data,
    output logic          m_valid,
    input  wire           m_ready,
    output tdaq_pkg::out_t m_data
);
    import tdaq_pkg::*;

    logic                          s1_valid_reg;
    in_t                           s1_data_reg;
    logic signed [SampleWidth-1:0] s1_prev_x_reg;
    logic signed [SampleWidth-1:0] s1_prev_y_reg;
    logic signed [SampleWidth-1:0] prev_x_reg;
    logic signed [SampleWidth-1:0] prev_y_reg;
    logic                          m_valid_reg;
    out_t                          m_data_reg;
    out_t                          m_data_next;
    logic                          advance;
    logic                          s_fire;

    assign advance = !m_valid_reg || m_ready;
    assign s_ready = !s1_valid_reg || advance;
    assign s_fire  = s_valid && s_ready;

    assign m_data_next.x_level = quantize(s1_data_reg.x_value, s1_prev_x_reg);
    assign m_data_next.y_level = quantize(s1_data_reg.y_value, s1_prev_y_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            prev_x_reg   <= '0;
            prev_y_reg   <= '0;
        end else begin
            if (s_fire) begin
                s1_valid_reg <= 1'b1;
                prev_x_reg   <= s_data.x_value;
                prev_y_reg   <= s_data.y_value;
            end else if (advance) begin
                s1_valid_reg <= 1'b0;
            end
            if (advance) begin
                m_valid_reg <= s1_valid_reg;
            end
        end
    end

    // payload registers; previous sample is captured alongside the new one
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            s1_data_reg   <= s_data;
            s1_prev_x_reg <= prev_x_reg;
            s1_prev_y_reg <= prev_y_reg;
        end
        if (advance && s1_valid_reg) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

>>> hdl/tdaq_checker.sv
// tdaq_checker.sv: port-level checks for the quantizer and their bind
`default_nettype none

module tdaq_checker (
    input wire            aclk,
    input wire            aresetn,
    input wire            s_valid,
    input wire            s_ready,
    input tdaq_pkg::in_t  s_data,
    input wire            m_valid,
    input wire            m_ready,
    input tdaq_pkg::out_t m_data
);
    import tdaq_pkg::*;

    // no result right after reset
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // stalled result holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // a draining output side never blocks the input side
    a_no_block: assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready |-> s_ready)
        else $error("input blocked while output drains");

    // level -8 cannot be produced on either axis
    a_level_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.x_level != LEVEL_NEG_FULL) && (m_data.y_level != LEVEL_NEG_FULL))
        else $error("level out of range");

endmodule

bind two_axis_direction_aware_quantizer_core tdaq_checker u_tdaq_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire

>>> test/tb_top.sv
// tb_top.sv: self-checking testbench for the two-axis direction-aware quantizer core
`timescale 1ns / 1ps

module tb_top;

    import tdaq_pkg::*;

    localparam int RandomItems = 1650;
    localparam int DirectedItems = 25;

    // walks across both ends of the range and both sides of several thresholds
    localparam int DIR_X [DirectedItems] = '{
        0, 0, 32767, -32768, -30721, -30721, -30722, -9581, -9582, -9581,
        9580, 9581, 9580, 9579, 30720, 30721, 30720, 32767, -1, 1,
        12600, 12599, 24680, 24681, 24680
    };
    localparam int DIR_Y [DirectedItems] = '{
        0, -1, -32768, 32767, 30720, 30719, 30720, 9580, 9579, 9580,
        -9581, -9580, -9581, -9582, -30721, -30722, -30721, -32768, 1, -1,
        -12601, -12600, -24681, -24682, -24681
    };

    logic   aclk = 1'b0;
    logic   aresetn = 1'b0;
    logic   s_valid = 1'b0;
    logic   s_ready;
    in_t    s_data = '0;
    logic   m_valid;
    logic   m_ready = 1'b0;
    out_t   m_data;

    in_t    item_q [$];
    out_t   level_q [$];

    int     total_items;
    int     sent_count = 0;
    int     results_seen = 0;
    int     mismatch_count = 0;
    int     gap_left = 0;
    int     stall_left = 0;
    int     hold_left = 0;
    bit     hold_done = 1'b0;
    bit     drain_wait = 1'b0;
    logic signed [15:0] prior_x = '0;
    logic signed [15:0] prior_y = '0;
    out_t   predicted;
    out_t   want;

    always #1 aclk = ~aclk;

    two_axis_direction_aware_quantizer_core u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    function automatic int threshold_at(input int idx);
        return (idx < 8) ? (-30721 + 3020 * idx) : (30720 - 3020 * (15 - idx));
    endfunction

    // rising or equal counts thresholds reached, falling takes highest one strictly below
    function automatic logic signed [3:0] predict_level(
        input logic signed [15:0] sample,
        input logic signed [15:0] prior
    );
        int cnt;
        int top_idx;
        int lvl;
        cnt = 0;
        top_idx = 0;
        for (int k = 0; k < 16; k++) begin
            if (threshold_at(k) <= int'(sample)) begin
                cnt++;
            end
            if (threshold_at(k) < int'(sample)) begin
                top_idx = k;
            end
        end
        if (sample >= prior) begin
            if (cnt > 15) begin
                cnt = 15;
            end
            lvl = cnt - 8;
            if (lvl < -7) begin
                lvl = -7;
            end
        end else begin
            lvl = top_idx - 7;
            if (lvl > 7) begin
                lvl = 7;
            end
        end
        return 4'(lvl);
    endfunction

    // mostly short gaps, some medium, a few long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end else if (r < 98) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    // biased toward threshold neighborhoods and repeats of the last sample
    function automatic logic signed [15:0] next_sample(input logic signed [15:0] last);
        int r;
        r = $urandom_range(0, 9);
        if (r < 4) begin
            return 16'(threshold_at($urandom_range(0, 15)) + $urandom_range(0, 4) - 2);
        end else if (r == 4) begin
            return last;
        end else if (r == 5) begin
            return last + 16'($urandom_range(0, 6)) - 16'sd3;
        end
        return 16'($urandom());
    endfunction

    // input side: offers queued items, predicts levels on each transfer
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            prior_x = '0;
            prior_y = '0;
        end else begin
            if (s_valid && s_ready) begin
                predicted.x_level = predict_level(s_data.x_value, prior_x);
                predicted.y_level = predict_level(s_data.y_value, prior_y);
                level_q.push_back(predicted);
                prior_x = s_data.x_value;
                prior_y = s_data.y_value;
                sent_count++;
                if (sent_count % 500 == 0) begin
                    drain_wait = 1'b1;
                end
            end
            if (!s_valid || s_ready) begin
                if (drain_wait && level_q.size() == 0) begin
                    drain_wait = 1'b0;
                end
                if (drain_wait) begin
                    s_valid <= 1'b0;
                end else if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (item_q.size() != 0) begin
                    s_data <= item_q.pop_front();
                    s_valid <= 1'b1;
                    gap_left = ((sent_count / 250) % 3 == 2) ? 0 : idle_len();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result side: random back-pressure, one long hold, compares against predictions
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (level_q.size() == 0) begin
                    $display("%0t: result with no prediction pending: x_level=%0d y_level=%0d",
                             $time, m_data.x_level, m_data.y_level);
                    mismatch_count++;
                end else begin
                    want = level_q.pop_front();
                    if (m_data.x_level !== want.x_level) begin
                        $display("%0t: x_level mismatch: expected %0d, actual %0d",
                                 $time, want.x_level, m_data.x_level);
                        mismatch_count++;
                    end
                    if (m_data.y_level !== want.y_level) begin
                        $display("%0t: y_level mismatch: expected %0d, actual %0d",
                                 $time, want.y_level, m_data.y_level);
                        mismatch_count++;
                    end
                end
            end
            if (results_seen == 700 && !hold_done) begin
                hold_done = 1'b1;
                hold_left = 300;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                stall_left = ((results_seen / 250) % 3 == 1) ? 0 : idle_len();
            end
        end
    end

    initial begin
        in_t item;
        logic signed [15:0] gx;
        logic signed [15:0] gy;
        for (int i = 0; i < DirectedItems; i++) begin
            item.x_value = 16'(DIR_X[i]);
            item.y_value = 16'(DIR_Y[i]);
            item_q.push_back(item);
        end
        gx = item.x_value;
        gy = item.y_value;
        for (int i = 0; i < RandomItems; i++) begin
            gx = next_sample(gx);
            gy = next_sample(gy);
            item.x_value = gx;
            item.y_value = gy;
            item_q.push_back(item);
        end
        total_items = item_q.size();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        wait (sent_count == total_items);
        wait (level_q.size() == 0);
        repeat (8) @(posedge aclk);
        $display("checked %0d level pairs from %0d directed and %0d random samples",
                 results_seen, DirectedItems, RandomItems);
        $display("threshold ties hit from both directions, %0d mismatches", mismatch_count);
        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("timeout: %0d of %0d items sent, %0d results outstanding",
                 sent_count, total_items, level_q.size());
        $display("Some tests failed");
        $finish;
    end

endmodule
